@@ rtl/core/sawarq_pkg.sv @@
// shared types and codes of the stop-and-wait sender
`default_nettype none
package sawarq_pkg;

   localparam logic [12:0] FRAME_BYTES_MAX = 13'd4096;
   localparam logic [8:0]  SEND_COUNT_MAX  = 9'd511;
   localparam int          CMDQ_DEPTH      = 4;
   localparam int          RSPQ_DEPTH      = 4;

   // input command codes
   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_ACK     = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;

   // result kinds
   localparam logic [1:0] RES_SEND   = 2'd0;
   localparam logic [1:0] RES_DONE   = 2'd1;
   localparam logic [1:0] RES_GAVEUP = 2'd2;

   // frame kinds
   localparam logic [1:0] FR_INITIAL = 2'd0;
   localparam logic [1:0] FR_MIDDLE  = 2'd1;
   localparam logic [1:0] FR_FINAL   = 2'd2;

   // register indexes
   localparam logic CSR_FRAME_SIZE  = 1'b0;
   localparam logic CSR_RETRY_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      OP_START,
      OP_ACK,
      OP_TIMEOUT
   } op_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] file_length;
      logic        start_seq;
      logic        ack_number;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [1:0]  frame_kind;
      logic [31:0] frame_offset;
      logic [12:0] frame_length;
      logic        frame_seq;
      logic        is_resend;
      logic        last;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] file_length;
      logic        start_seq;
      logic        ack_number;
   } cls_type;

   // results that the back end writes in the same cycle
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } rsp_wr_type;

endpackage
`default_nettype wire

@@ rtl/core/sawarq_front.sv @@
// front end: takes request beats, classifies them and queues the known ones for the back end
`default_nettype none
module sawarq_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   output logic                full,
   input  sawarq_pkg::req_type req_data,
   output logic                cls_valid,
   input  wire                 cls_take,
   output sawarq_pkg::cls_type cls_data
);
   import sawarq_pkg::*;

   localparam int PtrW = $clog2(CMDQ_DEPTH);
   localparam int CntW = $clog2(CMDQ_DEPTH + 1);

   cls_type         mem [CMDQ_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   cls_type         cls_item;
   logic            cls_known;
   logic            wr_en, rd_en;

   always_comb begin
      cls_item.file_length = req_data.file_length;
      cls_item.start_seq   = req_data.start_seq;
      cls_item.ack_number  = req_data.ack_number;
      cls_known            = 1'b1;
      case (req_data.cmd)
         CMD_START:   cls_item.op = OP_START;
         CMD_ACK:     cls_item.op = OP_ACK;
         CMD_TIMEOUT: cls_item.op = OP_TIMEOUT;
         default: begin
            // unknown command: beat is taken and dropped
            cls_item.op = OP_TIMEOUT;
            cls_known   = 1'b0;
         end
      endcase
   end

   assign full      = (count_ff == CntW'(CMDQ_DEPTH));
   assign cls_valid = (count_ff != '0);
   assign cls_data  = mem[rd_ptr_ff];
   assign wr_en     = push && !full && cls_known;
   assign rd_en     = cls_take && cls_valid;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + CntW'(wr_en) - CntW'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= cls_item;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/sawarq_back.sv @@
// back end: transfer state, framing, retry counting and the register file
`default_nettype none
module sawarq_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_valid,
   input  wire                    csr_index,
   input  wire  [12:0]            csr_wdata,
   input  wire                    cls_valid,
   output logic                   cls_take,
   input  sawarq_pkg::cls_type    cls_data,
   input  wire                    rsp_room,
   output sawarq_pkg::rsp_wr_type rsp_wr
);
   import sawarq_pkg::*;

   logic [12:0] frame_size_ff;
   logic [7:0]  retry_limit_ff;

   logic        busy_ff, busy_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [31:0] next_offset_ff, next_offset_in;
   logic        seq_ff, seq_in;
   logic [8:0]  send_count_ff, send_count_in;
   logic        final_ff, final_in;
   logic [1:0]  cur_kind_ff, cur_kind_in;
   logic [12:0] cur_length_ff, cur_length_in;
   logic [31:0] cur_offset_ff, cur_offset_in;

   logic [12:0] size_eff;
   logic        do_build, build_first, do_send, do_done, resend, gave_up;
   logic        exec;

   assign exec     = cls_valid && rsp_room;
   assign cls_take = exec;

   always_comb begin
      if (frame_size_ff == '0) begin
         size_eff = 13'd1;
      end else if (frame_size_ff > FRAME_BYTES_MAX) begin
         size_eff = FRAME_BYTES_MAX;
      end else begin
         size_eff = frame_size_ff;
      end
   end

   always_comb begin
      busy_in        = busy_ff;
      remaining_in   = remaining_ff;
      next_offset_in = next_offset_ff;
      seq_in         = seq_ff;
      send_count_in  = send_count_ff;
      final_in       = final_ff;
      cur_kind_in    = cur_kind_ff;
      cur_length_in  = cur_length_ff;
      cur_offset_in  = cur_offset_ff;
      do_build       = 1'b0;
      build_first    = 1'b0;
      do_send        = 1'b0;
      do_done        = 1'b0;
      resend         = 1'b0;
      gave_up        = 1'b0;

      if (exec) begin
         case (cls_data.op)
            OP_START: begin
               if (!busy_ff) begin
                  busy_in        = 1'b1;
                  remaining_in   = cls_data.file_length;
                  next_offset_in = '0;
                  seq_in         = cls_data.start_seq;
                  do_build       = 1'b1;
                  build_first    = 1'b1;
                  do_send        = 1'b1;
               end
            end
            OP_ACK, OP_TIMEOUT: begin
               if (busy_ff) begin
                  if (cls_data.op == OP_ACK && cls_data.ack_number == seq_ff) begin
                     if (final_ff) begin
                        do_done = 1'b1;
                        busy_in = 1'b0;
                     end else begin
                        remaining_in   = remaining_ff - 32'(cur_length_ff);
                        next_offset_in = next_offset_ff + 32'(cur_length_ff);
                        seq_in         = !seq_ff;
                        do_build       = 1'b1;
                        do_send        = 1'b1;
                     end
                  end else begin
                     do_send = 1'b1;
                     resend  = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (do_build) begin
         cur_offset_in = next_offset_in;
         send_count_in = '0;
         if (remaining_in > 32'(size_eff)) begin
            cur_length_in = size_eff;
            cur_kind_in   = build_first ? FR_INITIAL : FR_MIDDLE;
            final_in      = 1'b0;
         end else begin
            // rest of the file fits, so at most FRAME_BYTES_MAX bytes
            cur_length_in = remaining_in[12:0];
            cur_kind_in   = FR_FINAL;
            final_in      = 1'b1;
         end
      end

      if (do_send) begin
         if (send_count_in != SEND_COUNT_MAX) begin
            send_count_in = send_count_in + 9'd1;
         end
         if (final_in && send_count_in > {1'b0, retry_limit_ff}) begin
            gave_up = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_wr.first.result_kind  = do_done ? RES_DONE : RES_SEND;
      rsp_wr.first.frame_kind   = cur_kind_in;
      rsp_wr.first.frame_offset = cur_offset_in;
      rsp_wr.first.frame_length = cur_length_in;
      rsp_wr.first.frame_seq    = seq_in;
      rsp_wr.first.is_resend    = resend;
      rsp_wr.first.last         = !gave_up;
      rsp_wr.second             = rsp_wr.first;
      rsp_wr.second.result_kind = RES_GAVEUP;
      rsp_wr.second.is_resend   = 1'b0;
      rsp_wr.second.last        = 1'b1;
      if (gave_up) begin
         rsp_wr.count = 2'd2;
      end else if (do_send || do_done) begin
         rsp_wr.count = 2'd1;
      end else begin
         rsp_wr.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff  <= FRAME_BYTES_MAX;
         retry_limit_ff <= 8'd7;
         busy_ff        <= 1'b0;
         remaining_ff   <= '0;
         next_offset_ff <= '0;
         seq_ff         <= 1'b0;
         send_count_ff  <= '0;
         final_ff       <= 1'b0;
         cur_kind_ff    <= FR_INITIAL;
         cur_length_ff  <= '0;
         cur_offset_ff  <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_FRAME_SIZE:  frame_size_ff  <= csr_wdata;
               CSR_RETRY_LIMIT: retry_limit_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
         busy_ff        <= busy_in;
         remaining_ff   <= remaining_in;
         next_offset_ff <= next_offset_in;
         seq_ff         <= seq_in;
         send_count_ff  <= send_count_in;
         final_ff       <= final_in;
         cur_kind_ff    <= cur_kind_in;
         cur_length_ff  <= cur_length_in;
         cur_offset_ff  <= cur_offset_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/sawarq_rspq.sv @@
// result queue: takes up to two results a cycle, hands out one per pop
`default_nettype none
module sawarq_rspq (
   input  wire                    clock,
   input  wire                    reset,
   input  sawarq_pkg::rsp_wr_type rsp_wr,
   output logic                   rsp_room,
   output logic                   empty,
   input  wire                    pop,
   output sawarq_pkg::rsp_type    rsp_data
);
   import sawarq_pkg::*;

   localparam int PtrW = $clog2(RSPQ_DEPTH);
   localparam int CntW = $clog2(RSPQ_DEPTH + 1);

   rsp_type         mem [RSPQ_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            rd_en;

   // the back end may write two results, so keep two slots free
   assign rsp_room = (count_ff <= CntW'(RSPQ_DEPTH - 2));
   assign empty    = (count_ff == '0);
   assign rsp_data = mem[rd_ptr_ff];
   assign rd_en    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(rsp_wr.count);
      rd_ptr_in = rd_en ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + CntW'(rsp_wr.count) - CntW'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_wr.count != 2'd0) begin
         mem[wr_ptr_ff] <= rsp_wr.first;
      end
      if (rsp_wr.count == 2'd2) begin
         mem[wr_ptr_ff + PtrW'(1)] <= rsp_wr.second;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/stop_and_wait_arq_sender_top.sv @@
// Stop-and-wait (alternating bit) sender: control path top level.
// A start beat loads the file length and first sequence bit; the block issues one send
// result per frame, advances on a matching ack, resends on a timeout or a wrong ack and
// reports completion or give-up on the final frame. A request beat is taken every cycle
// while full is low; it is registered in the command queue, and the back end takes it from
// there and registers its results in the result queue. The back end handles one beat per
// cycle while the result queue has room; the result queue drains one result per pop, so a
// beat that causes two results (send plus give-up) costs two pops. Ignored beats produce no
// result. Register writes are taken every cycle (csr_ready is always high).
`default_nettype none
module stop_and_wait_arq_sender_top (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   output logic                full,
   input  sawarq_pkg::req_type req_data,
   output logic                empty,
   input  wire                 pop,
   output sawarq_pkg::rsp_type rsp_data,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire                 csr_index,
   input  wire  [12:0]         csr_wdata
);
   import sawarq_pkg::*;

   logic       cls_valid;
   logic       cls_take;
   cls_type    cls_data;
   logic       rsp_room;
   rsp_wr_type rsp_wr;

   assign csr_ready = 1'b1;

   sawarq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cls_valid (cls_valid),
      .cls_take  (cls_take),
      .cls_data  (cls_data)
   );

   sawarq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cls_valid (cls_valid),
      .cls_take  (cls_take),
      .cls_data  (cls_data),
      .rsp_room  (rsp_room),
      .rsp_wr    (rsp_wr)
   );

   sawarq_rspq u_rspq (
      .clock    (clock),
      .reset    (reset),
      .rsp_wr   (rsp_wr),
      .rsp_room (rsp_room),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

@@ rtl/core/sawarq_checker.sv @@
// port-level checks of the stop-and-wait sender, bound to the top level
`default_nettype none
module sawarq_checker (
   input wire                 clock,
   input wire                 reset,
   input wire                 empty,
   input wire                 pop,
   input sawarq_pkg::rsp_type rsp_data
);
   import sawarq_pkg::*;

   // nothing waits straight after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result queue not empty after reset");

   // a waiting result beat holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result beat changed");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.result_kind == RES_SEND || rsp_data.result_kind == RES_DONE
                  || rsp_data.result_kind == RES_GAVEUP))
      else $error("illegal result kind");

   // completion and give-up close the beat's results and are never resends
   a_end_marks: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.result_kind != RES_SEND) |-> (rsp_data.last && !rsp_data.is_resend))
      else $error("end result with wrong marks");

   // only the final frame completes or gives up
   a_end_final: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.result_kind != RES_SEND) |-> (rsp_data.frame_kind == FR_FINAL))
      else $error("end result on a non-final frame");

endmodule

bind stop_and_wait_arq_sender_top sawarq_checker u_sawarq_checker (.*);
`default_nettype wire
